// ===== hdl/msqrt_pkg.sv =====
package msqrt_pkg;

    localparam int W = 32;
    localparam int CW = 6;

    typedef logic [W-1:0] word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CLASSIFY,
        ST_EULER_SETUP,
        ST_POW_STEP,
        ST_MUL_RUN,
        ST_EULER_DONE,
        ST_ZSCAN_NEXT,
        ST_ZSCAN_DONE,
        ST_C_DONE,
        ST_R_DONE,
        ST_T_DONE,
        ST_LOOP_TOP,
        ST_SQ_DONE,
        ST_BSQ_DONE,
        ST_RB_DONE,
        ST_BB_DONE,
        ST_TBB_DONE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PW_EULER,
        PW_SHORT,
        PW_ZTEST,
        PW_C,
        PW_R,
        PW_T
    } pow_t;

endpackage

// ===== hdl/modular_square_root_unit.sv =====
// Modular square root unit (Tonelli-Shanks), digit serial.
//
// Write the 32-bit modulus through cfg_we/cfg_data while the unit is idle;
// it resets to 3. Pulse start with value while busy is low to issue a
// request. busy stays high while the request is worked on. When the answer
// is ready, done is high for exactly one cycle with root and has_root; the
// receiver cannot stall and must take it in that cycle. busy falls in the
// cycle done is shown, so the next request can be issued right after.
//
// Every modular product goes through one bit-serial multiplier that takes
// one multiplier bit per cycle; the input reduction is a restoring
// divider, one bit per cycle. Latency is data dependent: it grows when
// p - 1 carries many factors of two or the non-residue scan runs long.
// One request is in flight at a time.
// Reset returns the unit to idle with no request pending.
module modular_square_root_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_data,
    input  logic                   start,
    input  logic [31:0]            value,
    output logic                   busy,
    output logic                   done,
    output logic [31:0]            root,
    output logic                   has_root
);
    import msqrt_pkg::*;

    state_t state_reg, state_next;
    pow_t   pow_reg, pow_next;
    state_t ret_reg, ret_next;

    word_t p_reg;
    word_t n_reg, n_next;
    word_t q_reg, q_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] m_reg, m_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    word_t z_reg, z_next;
    word_t c_reg, c_next;
    word_t r_reg, r_next;
    word_t t_reg, t_next;
    word_t b_reg, b_next;
    word_t sq_reg, sq_next;

    word_t pb_reg, pb_next;
    word_t pr_reg, pr_next;
    word_t pe_reg, pe_next;
    logic  sqphase_reg, sqphase_next;

    word_t ma_reg, ma_next;
    word_t mb_reg, mb_next;
    word_t macc_reg, macc_next;

    word_t dq_reg, dq_next;
    logic [W:0] drem_reg, drem_next;

    word_t root_reg, root_next;
    logic  has_reg, has_next;
    logic  done_reg, done_next;

    function automatic word_t addm(word_t a, word_t b, word_t m);
        logic [W:0] s;
        logic [W:0] d;
        begin
            s = {1'b0, a} + {1'b0, b};
            d = s - {1'b0, m};
            addm = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
        end
    endfunction

    word_t dbl;
    word_t dbla;
    logic [W:0] dtry;

    always_comb
    begin
        dbl  = addm(macc_reg, macc_reg, p_reg);
        dbla = mb_reg[W-1] ? addm(dbl, ma_reg, p_reg) : dbl;
        dtry = {drem_reg[W-1:0], dq_reg[W-1]} - {1'b0, p_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            p_reg     <= word_t'(3);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
                p_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pow_reg <= pow_next; ret_reg <= ret_next;
        n_reg <= n_next; q_reg <= q_next; s_reg <= s_next; m_reg <= m_next;
        i_reg <= i_next; cnt_reg <= cnt_next; z_reg <= z_next;
        c_reg <= c_next; r_reg <= r_next; t_reg <= t_next; b_reg <= b_next;
        sq_reg <= sq_next; pb_reg <= pb_next; pr_reg <= pr_next;
        pe_reg <= pe_next; sqphase_reg <= sqphase_next;
        ma_reg <= ma_next; mb_reg <= mb_next; macc_reg <= macc_next;
        dq_reg <= dq_next; drem_reg <= drem_next;
        root_reg <= root_next; has_reg <= has_next;
    end

    always_comb
    begin
        state_next = state_reg; pow_next = pow_reg; ret_next = ret_reg;
        n_next = n_reg; q_next = q_reg; s_next = s_reg; m_next = m_reg;
        i_next = i_reg; cnt_next = cnt_reg; z_next = z_reg;
        c_next = c_reg; r_next = r_reg; t_next = t_reg; b_next = b_reg;
        sq_next = sq_reg; pb_next = pb_reg; pr_next = pr_reg;
        pe_next = pe_reg; sqphase_next = sqphase_reg;
        ma_next = ma_reg; mb_next = mb_reg; macc_next = macc_reg;
        dq_next = dq_reg; drem_next = drem_reg;
        root_next = root_reg; has_next = has_reg;
        done_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dq_next   = value;
                    drem_next = '0;
                    cnt_next  = '0;
                    root_next = '0;
                    has_next  = 1'b0;
                    if (p_reg == '0)
                        state_next = ST_FINISH;
                    else if (p_reg == word_t'(1))
                    begin
                        has_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_REDUCE;
                end
            end

            // restoring division, one quotient bit a cycle; keep remainder
            ST_REDUCE:
            begin
                if (!dtry[W])
                    drem_next = dtry;
                else
                    drem_next = {drem_reg[W-1:0], dq_reg[W-1]};
                dq_next  = {dq_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                    state_next = ST_CLASSIFY;
            end

            ST_CLASSIFY:
            begin
                n_next = drem_reg[W-1:0];
                q_next = p_reg - 1'b1;
                s_next = '0;
                if (p_reg == word_t'(2))
                begin
                    root_next  = drem_reg[W-1:0];
                    has_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (!p_reg[0])
                    state_next = ST_FINISH;
                else if (drem_reg[W-1:0] == '0)
                begin
                    has_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_EULER_SETUP;
            end

            // strip factors of two from p-1, then test Euler's criterion
            ST_EULER_SETUP:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    pb_next = n_reg; pe_next = p_reg >> 1; pr_next = word_t'(1);
                    pow_next = PW_EULER; sqphase_next = 1'b0;
                    state_next = ST_POW_STEP;
                end
            end

            // square-and-multiply: launch one product at a time
            ST_POW_STEP:
            begin
                if (pe_reg == '0)
                begin
                    unique case (pow_reg)
                        PW_EULER: state_next = ST_EULER_DONE;
                        PW_SHORT:
                        begin
                            root_next = pr_reg; has_next = 1'b1;
                            state_next = ST_FINISH;
                        end
                        PW_ZTEST: state_next = ST_ZSCAN_DONE;
                        PW_C:     state_next = ST_C_DONE;
                        PW_R:     state_next = ST_R_DONE;
                        PW_T:     state_next = ST_T_DONE;
                        default:  state_next = ST_FINISH;
                    endcase
                end
                else
                begin
                    macc_next = '0; cnt_next = '0;
                    ret_next = ST_POW_STEP;
                    state_next = ST_MUL_RUN;
                    if (!sqphase_reg && pe_reg[0])
                    begin
                        ma_next = pr_reg; mb_next = pb_reg;
                    end
                    else
                    begin
                        ma_next = pb_reg; mb_next = pb_reg;
                    end
                end
            end

            ST_MUL_RUN:
            begin
                macc_next = dbla;
                mb_next   = {mb_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = ret_reg;
                    if (ret_reg == ST_POW_STEP)
                    begin
                        if (!sqphase_reg && pe_reg[0])
                        begin
                            pr_next = dbla; sqphase_next = 1'b1;
                        end
                        else
                        begin
                            pb_next = dbla; pe_next = pe_reg >> 1;
                            sqphase_next = 1'b0;
                        end
                    end
                end
            end

            ST_EULER_DONE:
            begin
                if (pr_reg != word_t'(1))
                    state_next = ST_FINISH;
                else if (s_reg == CW'(1))
                begin
                    pb_next = n_reg; pe_next = (p_reg >> 2) + 1'b1;
                    pr_next = word_t'(1); pow_next = PW_SHORT;
                    state_next = ST_POW_STEP;
                end
                else
                begin
                    z_next = word_t'(2);
                    state_next = ST_ZSCAN_NEXT;
                end
            end

            ST_ZSCAN_NEXT:
            begin
                if (z_reg >= p_reg)
                    state_next = ST_FINISH;
                else
                begin
                    pb_next = z_reg; pe_next = p_reg >> 1; pr_next = word_t'(1);
                    pow_next = PW_ZTEST; state_next = ST_POW_STEP;
                end
            end

            ST_ZSCAN_DONE:
            begin
                if (pr_reg == word_t'(1))
                begin
                    z_next = z_reg + 1'b1;
                    state_next = ST_ZSCAN_NEXT;
                end
                else
                begin
                    pb_next = z_reg; pe_next = q_reg; pr_next = word_t'(1);
                    pow_next = PW_C; state_next = ST_POW_STEP;
                end
            end

            ST_C_DONE:
            begin
                c_next = pr_reg;
                pb_next = n_reg; pe_next = (q_reg >> 1) + 1'b1;
                pr_next = word_t'(1); pow_next = PW_R; state_next = ST_POW_STEP;
            end

            ST_R_DONE:
            begin
                r_next = pr_reg;
                pb_next = n_reg; pe_next = q_reg; pr_next = word_t'(1);
                pow_next = PW_T; state_next = ST_POW_STEP;
            end

            ST_T_DONE:
            begin
                t_next = pr_reg; m_next = s_reg;
                state_next = ST_LOOP_TOP;
            end

            ST_LOOP_TOP:
            begin
                if (t_reg == word_t'(1))
                begin
                    root_next = r_reg; has_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    i_next = CW'(1);
                    ma_next = t_reg; mb_next = t_reg; macc_next = '0;
                    cnt_next = '0; ret_next = ST_SQ_DONE;
                    state_next = ST_MUL_RUN;
                end
            end

            ST_SQ_DONE:
            begin
                if (i_reg < m_reg && macc_reg != word_t'(1))
                begin
                    i_next = i_reg + 1'b1;
                    ma_next = macc_reg; mb_next = macc_reg; macc_next = '0;
                    cnt_next = '0; ret_next = ST_SQ_DONE;
                    state_next = ST_MUL_RUN;
                end
                else if (i_reg >= m_reg)
                    state_next = ST_FINISH;
                else
                begin
                    b_next = c_reg; sq_next = word_t'({{(W-CW){1'b0}}, i_reg} + 1'b1);
                    state_next = ST_BSQ_DONE;
                    macc_next = c_reg;
                end
            end

            // square b until its exponent index reaches m, then launch the r*b product
            ST_BSQ_DONE:
            begin
                b_next = macc_reg;
                if (sq_reg[CW-1:0] < m_reg)
                begin
                    sq_next = sq_reg + 1'b1;
                    ma_next = macc_reg; mb_next = macc_reg; macc_next = '0;
                    cnt_next = '0; ret_next = ST_BSQ_DONE;
                    state_next = ST_MUL_RUN;
                end
                else
                begin
                    ma_next = r_reg; mb_next = macc_reg; macc_next = '0;
                    cnt_next = '0; ret_next = ST_RB_DONE;
                    state_next = ST_MUL_RUN;
                end
            end

            ST_RB_DONE:
            begin
                r_next = macc_reg;
                ma_next = b_reg; mb_next = b_reg; macc_next = '0;
                cnt_next = '0; ret_next = ST_BB_DONE;
                state_next = ST_MUL_RUN;
            end

            ST_BB_DONE:
            begin
                c_next = macc_reg;
                ma_next = t_reg; mb_next = macc_reg; macc_next = '0;
                cnt_next = '0; ret_next = ST_TBB_DONE;
                state_next = ST_MUL_RUN;
            end

            ST_TBB_DONE:
            begin
                t_next = macc_reg; m_next = i_reg;
                state_next = ST_LOOP_TOP;
            end

            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign root     = root_reg;
    assign has_root = has_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_FINISH) else $error("stray done");
    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !has_root) |-> root == '0) else $error("root without has_root");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

endmodule
